### sv/terminal_key_sequence_decoder_defines.svh
// Assertion macros used by the checker file.
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_DEFINES_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_DEFINES_SVH

// Clocked property, ignored while reset is high.
`define TKSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define TKSD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/tksd_pkg.sv
`timescale 1ns / 1ps

package tksd_pkg;

   localparam int BYTE_W = 8;
   localparam int NUM_W  = 16;
   localparam int RES_W  = NUM_W + 1;

   localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1B;
   localparam logic [BYTE_W-1:0] CH_CTRL_C = 8'h03;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7E;
   localparam logic [BYTE_W-1:0] CH_UP     = 8'h41;
   localparam logic [BYTE_W-1:0] CH_DOWN   = 8'h42;
   localparam logic [BYTE_W-1:0] CH_RIGHT  = 8'h43;
   localparam logic [BYTE_W-1:0] CH_LEFT   = 8'h44;
   localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

   localparam logic [BYTE_W-1:0] BACKSPACE_RESET = 8'h7F;
   localparam logic [NUM_W-1:0]  HOME_RESET      = 16'd1;
   localparam logic [NUM_W-1:0]  END_RESET       = 16'd4;
   localparam logic [NUM_W-1:0]  DELETE_RESET    = 16'd3;

   localparam logic [NUM_W-1:0]  NUM_MAX    = 16'hFFFF;
   localparam logic signed [RES_W-1:0] NUM_ABSENT = -17'sd1;

   typedef enum logic [1:0] {
      CSR_BACKSPACE = 2'd0,
      CSR_HOME      = 2'd1,
      CSR_END       = 2'd2,
      CSR_DELETE    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      EV_NONE    = 4'd0,
      EV_CHAR    = 4'd1,
      EV_ENTER   = 4'd2,
      EV_BS      = 4'd3,
      EV_CTRL_C  = 4'd4,
      EV_UP      = 4'd5,
      EV_DOWN    = 4'd6,
      EV_RIGHT   = 4'd7,
      EV_LEFT    = 4'd8,
      EV_HOME    = 4'd9,
      EV_END     = 4'd10,
      EV_DELETE  = 4'd11,
      EV_UNKNOWN = 4'd12
   } event_type;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_START  = 4'b0010,
      PH_FIRST  = 4'b0100,
      PH_SECOND = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [NUM_W-1:0] home_number;
      logic [NUM_W-1:0] end_number;
      logic [NUM_W-1:0] delete_number;
   } key_cfg_type;

   typedef struct packed {
      logic             present;
      logic [NUM_W-1:0] value;
   } num_type;

   function automatic logic signed [RES_W-1:0] to_result(input num_type n);
      logic signed [RES_W-1:0] r;
      r = n.present ? $signed({1'b0, n.value}) : NUM_ABSENT;
      return r;
   endfunction

endpackage

### sv/tksd_num_accum.sv
`timescale 1ns / 1ps

module tksd_num_accum
   import tksd_pkg::*;
(
   input  num_type    acc,
   input  logic [3:0] digit,
   output num_type    acc_next
);

   logic [NUM_W+3:0] scaled;

   // acc*10 + digit, at most 655365, fits 20 bits
   assign scaled = {1'b0, acc.value, 3'b000} + {3'b000, acc.value, 1'b0}
                 + {{NUM_W{1'b0}}, digit};

   always_comb begin
      acc_next.present = 1'b1;
      if (!acc.present) begin
         acc_next.value = {{(NUM_W-4){1'b0}}, digit};
      end else if (scaled[NUM_W+3:NUM_W] != 4'd0) begin
         acc_next.value = NUM_MAX;
      end else begin
         acc_next.value = scaled[NUM_W-1:0];
      end
   end

endmodule

### sv/tksd_key_decode.sv
`timescale 1ns / 1ps

module tksd_key_decode
   import tksd_pkg::*;
(
   input  logic [BYTE_W-1:0] final_byte,
   input  num_type           first,
   input  key_cfg_type       cfg,
   output event_type         key_event
);

   always_comb begin
      key_event = EV_UNKNOWN;
      priority if (final_byte == CH_UP) begin
         key_event = EV_UP;
      end else if (final_byte == CH_DOWN) begin
         key_event = EV_DOWN;
      end else if (final_byte == CH_RIGHT) begin
         key_event = EV_RIGHT;
      end else if (final_byte == CH_LEFT) begin
         key_event = EV_LEFT;
      end else if (final_byte == CH_TILDE && first.present) begin
         priority if (first.value == cfg.home_number) begin
            key_event = EV_HOME;
         end else if (first.value == cfg.end_number) begin
            key_event = EV_END;
         end else if (first.value == cfg.delete_number) begin
            key_event = EV_DELETE;
         end else begin
            key_event = EV_UNKNOWN;
         end
      end else begin
         key_event = EV_UNKNOWN;
      end
   end

endmodule

### sv/terminal_key_sequence_decoder.sv
`timescale 1ns / 1ps
// Channel   Ports                                      Direction  Transfer
// req       req_valid/req_ready, req_byte_in           in         valid & ready
// rsp       rsp_valid/rsp_ready, rsp_* result fields   out        valid & ready
// csr       csr_we, csr_index, csr_wdata               in         csr_we, no wait
//
// One word in, one result word out; the result shows in the cycle after accept.
// One word per cycle sustained while rsp_ready is high: decode is a single stage
// from the parse state and input byte into the output register.
// Synchronous reset: parse state idle, numbers absent, registers at defaults.
// A stalled result holds; a new word is taken in the cycle rsp_ready frees it.

module terminal_key_sequence_decoder
   import tksd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [BYTE_W-1:0]       req_byte_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [3:0]              rsp_event_res,
   output logic [BYTE_W-1:0]       rsp_char_out,
   output logic [BYTE_W-1:0]       rsp_final_byte,
   output logic signed [RES_W-1:0] rsp_first_number,
   output logic signed [RES_W-1:0] rsp_second_number,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [NUM_W-1:0]        csr_wdata
);

   logic [BYTE_W-1:0] backspace_ff;
   key_cfg_type       key_cfg_ff;

   phase_type phase_ff, phase_in;
   num_type   first_ff, first_in, second_ff, second_in;
   num_type   first_acc, second_acc;
   num_type   absent;

   logic                    rsp_valid_ff;
   event_type               event_ff, event_in, key_event;
   logic [BYTE_W-1:0]       char_ff, char_in, final_ff, final_in;
   logic signed [RES_W-1:0] n1_ff, n1_in, n2_ff, n2_in;

   logic accept, done, is_digit;

   assign absent    = '{present: 1'b0, value: '0};
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_digit  = (req_byte_in >= CH_ZERO) && (req_byte_in <= CH_NINE);

   tksd_num_accum u_first_accum (
      .acc      (first_ff),
      .digit    (req_byte_in[3:0]),
      .acc_next (first_acc)
   );

   tksd_num_accum u_second_accum (
      .acc      (second_ff),
      .digit    (req_byte_in[3:0]),
      .acc_next (second_acc)
   );

   tksd_key_decode u_key_decode (
      .final_byte (req_byte_in),
      .first      (first_ff),
      .cfg        (key_cfg_ff),
      .key_event  (key_event)
   );

   always_comb begin
      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      event_in  = EV_NONE;
      char_in   = '0;
      final_in  = '0;
      n1_in     = NUM_ABSENT;
      n2_in     = NUM_ABSENT;
      done      = 1'b0;
      if (req_byte_in == CH_ESC) begin
         phase_in  = PH_START;
         first_in  = absent;
         second_in = absent;
      end else begin
         unique case (phase_ff)
            PH_START: begin
               if (req_byte_in == CH_LBRACK) phase_in = PH_FIRST;
               else done = 1'b1;
            end
            PH_FIRST: begin
               if (is_digit) first_in = first_acc;
               else if (req_byte_in == CH_SEMI) phase_in = PH_SECOND;
               else done = 1'b1;
            end
            PH_SECOND: begin
               if (is_digit) second_in = second_acc;
               else done = 1'b1;
            end
            PH_IDLE: begin
               priority if (req_byte_in == CH_CTRL_C) begin
                  event_in = EV_CTRL_C;
               end else if (req_byte_in == CH_CR || req_byte_in == CH_LF) begin
                  event_in = EV_ENTER;
               end else if (req_byte_in == backspace_ff) begin
                  event_in = EV_BS;
               end else begin
                  event_in = EV_CHAR;
                  char_in  = req_byte_in;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         if (done) begin
            final_in  = req_byte_in;
            n1_in     = to_result(first_ff);
            n2_in     = to_result(second_ff);
            event_in  = key_event;
            phase_in  = PH_IDLE;
            first_in  = absent;
            second_in = absent;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         backspace_ff             <= BACKSPACE_RESET;
         key_cfg_ff.home_number   <= HOME_RESET;
         key_cfg_ff.end_number    <= END_RESET;
         key_cfg_ff.delete_number <= DELETE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BACKSPACE: backspace_ff             <= csr_wdata[BYTE_W-1:0];
            CSR_HOME:      key_cfg_ff.home_number   <= csr_wdata;
            CSR_END:       key_cfg_ff.end_number    <= csr_wdata;
            CSR_DELETE:    key_cfg_ff.delete_number <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         first_ff     <= '0;
         second_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            first_ff     <= first_in;
            second_ff    <= second_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff <= event_in;
         char_ff  <= char_in;
         final_ff <= final_in;
         n1_ff    <= n1_in;
         n2_ff    <= n2_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = event_ff;
   assign rsp_char_out      = char_ff;
   assign rsp_final_byte    = final_ff;
   assign rsp_first_number  = n1_ff;
   assign rsp_second_number = n2_ff;

endmodule

### sv/tksd_checker.sv
`timescale 1ns / 1ps
`include "terminal_key_sequence_decoder_defines.svh"

module tksd_checker
   import tksd_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [3:0]              rsp_event_res,
   input logic [BYTE_W-1:0]       rsp_final_byte,
   input logic signed [RES_W-1:0] rsp_first_number,
   input logic signed [RES_W-1:0] rsp_second_number
);

   `TKSD_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   `TKSD_ASSERT(a_word_yields_result, clock, reset,
      (req_valid && req_ready) |=> rsp_valid, "accepted word gave no result")

   `TKSD_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready,
      "not ready with empty output")

   `TKSD_ASSERT(a_rsp_holds, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_first_number)), "stalled result changed")

   `TKSD_ASSERT(a_plain_fields, clock, reset,
      (rsp_valid && rsp_event_res <= EV_CTRL_C) |-> (rsp_final_byte == 8'd0
         && rsp_first_number == NUM_ABSENT && rsp_second_number == NUM_ABSENT),
      "plain event carries sequence fields")

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (.*);

### tb/sv/tb_terminal_key_sequence_decoder.sv
`timescale 1ns / 1ps

module tb_terminal_key_sequence_decoder;
   import tksd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [3:0]              ev;
      logic [BYTE_W-1:0]       ch;
      logic [BYTE_W-1:0]       fin;
      logic signed [RES_W-1:0] n1;
      logic signed [RES_W-1:0] n2;
   } key_event_type;

   class key_event_scoreboard_type;
      logic [BYTE_W-1:0] backspace_code;
      logic [NUM_W-1:0]  home_code;
      logic [NUM_W-1:0]  end_code;
      logic [NUM_W-1:0]  delete_code;
      phase_type         phase;
      int                first_num;
      int                second_num;
      key_event_type     expected_q[$];
      int                errors;
      int                results_seen;

      function new();
         backspace_code = BACKSPACE_RESET;
         home_code      = HOME_RESET;
         end_code       = END_RESET;
         delete_code    = DELETE_RESET;
         phase          = PH_IDLE;
         first_num      = -1;
         second_num     = -1;
         errors         = 0;
         results_seen   = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [NUM_W-1:0] value);
         case (idx)
            CSR_BACKSPACE: backspace_code = value[BYTE_W-1:0];
            CSR_HOME:      home_code = value;
            CSR_END:       end_code = value;
            CSR_DELETE:    delete_code = value;
            default: ;
         endcase
      endfunction

      function int accumulate(int acc, int digit);
         int v;
         v = (acc < 0) ? 0 : acc * 10;
         v += digit;
         return (v > int'(NUM_MAX)) ? int'(NUM_MAX) : v;
      endfunction

      function event_type decode_key(logic [BYTE_W-1:0] fin, int n1);
         if (fin == CH_UP) return EV_UP;
         if (fin == CH_DOWN) return EV_DOWN;
         if (fin == CH_RIGHT) return EV_RIGHT;
         if (fin == CH_LEFT) return EV_LEFT;
         if (fin == CH_TILDE && n1 >= 0) begin
            if (n1 == int'(home_code)) return EV_HOME;
            if (n1 == int'(end_code)) return EV_END;
            if (n1 == int'(delete_code)) return EV_DELETE;
         end
         return EV_UNKNOWN;
      endfunction

      function void note_byte(logic [BYTE_W-1:0] c);
         key_event_type e;
         logic          done;
         logic          is_digit;
         e.ev = EV_NONE;
         e.ch = '0;
         e.fin = '0;
         e.n1 = NUM_ABSENT;
         e.n2 = NUM_ABSENT;
         done = 1'b0;
         is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
         if (c == CH_ESC) begin
            phase = PH_START;
            first_num = -1;
            second_num = -1;
         end else begin
            case (phase)
               PH_START: begin
                  if (c == CH_LBRACK) phase = PH_FIRST;
                  else done = 1'b1;
               end
               PH_FIRST: begin
                  if (is_digit) first_num = accumulate(first_num, int'(c - CH_ZERO));
                  else if (c == CH_SEMI) phase = PH_SECOND;
                  else done = 1'b1;
               end
               PH_SECOND: begin
                  if (is_digit) second_num = accumulate(second_num, int'(c - CH_ZERO));
                  else done = 1'b1;
               end
               default: begin
                  if (c == CH_CTRL_C) e.ev = EV_CTRL_C;
                  else if (c == CH_CR || c == CH_LF) e.ev = EV_ENTER;
                  else if (c == backspace_code) e.ev = EV_BS;
                  else begin
                     e.ev = EV_CHAR;
                     e.ch = c;
                  end
               end
            endcase
            if (done) begin
               e.fin = c;
               e.n1 = RES_W'(first_num);
               e.n2 = RES_W'(second_num);
               e.ev = decode_key(c, first_num);
               phase = PH_IDLE;
               first_num = -1;
               second_num = -1;
            end
         end
         expected_q.push_back(e);
      endfunction

      task report(string msg);
         errors++;
         if (errors < 200) $display("%0t error: word %0d: %s", $time, results_seen, msg);
      endtask

      task check_result(logic [3:0] ev, logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] fin,
                        logic signed [RES_W-1:0] n1, logic signed [RES_W-1:0] n2);
         key_event_type e;
         results_seen++;
         if (expected_q.size() == 0) begin
            report($sformatf("result with nothing pending, event %0d", ev));
            return;
         end
         e = expected_q.pop_front();
         if (ev !== e.ev) report($sformatf("event_res %0d, want %0d", ev, e.ev));
         if (ch !== e.ch) report($sformatf("char_out %0h, want %0h", ch, e.ch));
         if (fin !== e.fin) report($sformatf("final_byte %0h, want %0h", fin, e.fin));
         if (n1 !== e.n1) report($sformatf("first_number %0d, want %0d", n1, e.n1));
         if (n2 !== e.n2) report($sformatf("second_number %0d, want %0d", n2, e.n2));
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [BYTE_W-1:0]       req_byte_in;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [3:0]              rsp_event_res;
   logic [BYTE_W-1:0]       rsp_char_out;
   logic [BYTE_W-1:0]       rsp_final_byte;
   logic signed [RES_W-1:0] rsp_first_number;
   logic signed [RES_W-1:0] rsp_second_number;
   logic                    csr_we;
   logic [1:0]              csr_index;
   logic [NUM_W-1:0]        csr_wdata;

   key_event_scoreboard_type sb;
   int cycles;
   int sent;
   int burst_left;
   int stall_mode;
   int stall_left;
   int stall_tick;

   terminal_key_sequence_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_in       (req_byte_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_res     (rsp_event_res),
      .rsp_char_out      (rsp_char_out),
      .rsp_final_byte    (rsp_final_byte),
      .rsp_first_number  (rsp_first_number),
      .rsp_second_number (rsp_second_number),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: check, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_event_res, rsp_char_out, rsp_final_byte,
                         rsp_first_number, rsp_second_number);
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 300);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= (stall_tick % 5) < 3;
         default: rsp_ready <= (stall_tick % 11) < 2;
      endcase
   end

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      pace();
      req_valid <= 1'b1;
      req_byte_in <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b);
      sent++;
   endtask

   task automatic send_number(input int n, input bit leading_zero);
      string s;
      s = $sformatf("%0d", n);
      if (leading_zero) send_byte(CH_ZERO);
      foreach (s[i]) send_byte(s[i]);
   endtask

   function automatic int pick_number();
      case ($urandom_range(0, 5))
         0: return int'(sb.home_code);
         1: return int'(sb.end_code);
         2: return int'(sb.delete_code);
         3: return $urandom_range(0, 20);
         4: return $urandom_range(0, 65535);
         default: return $urandom_range(65536, 9999999);
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] pick_final();
      case ($urandom_range(0, 9))
         0, 1, 2: return CH_TILDE;
         3: return CH_UP;
         4: return CH_DOWN;
         5: return CH_RIGHT;
         6: return CH_LEFT;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic random_sequence();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
         case ($urandom_range(0, 5))
            0: send_byte(CH_CTRL_C);
            1: send_byte(CH_CR);
            2: send_byte(CH_LF);
            3: send_byte(sb.backspace_code);
            default: send_byte(BYTE_W'($urandom_range(0, 255)));
         endcase
      end else if (kind < 80) begin
         send_byte(CH_ESC);
         send_byte(CH_LBRACK);
         if ($urandom_range(0, 3) != 0) send_number(pick_number(), $urandom_range(0, 7) == 0);
         if ($urandom_range(0, 3) == 0) begin
            send_byte(CH_SEMI);
            if ($urandom_range(0, 2) != 0) send_number(pick_number(), 1'b0);
         end
         send_byte(pick_final());
      end else if (kind < 90) begin
         send_byte(CH_ESC);
         send_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 4))
               0: send_byte(CH_ESC);
               1: send_byte(CH_LBRACK);
               2: send_byte(CH_SEMI);
               3: send_byte(CH_ZERO + BYTE_W'($urandom_range(0, 9)));
               default: send_byte(BYTE_W'($urandom_range(0, 255)));
            endcase
         end
      end
   endtask

   task automatic run_random(input int target);
      while (sent < target) random_sequence();
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [NUM_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic set_regs(input logic [BYTE_W-1:0] bs, input logic [NUM_W-1:0] home,
                           input logic [NUM_W-1:0] end_key, input logic [NUM_W-1:0] del);
      logic [BYTE_W-1:0] upper;
      upper = BYTE_W'($urandom_range(0, 255));
      csr_write(CSR_BACKSPACE, {upper, bs});
      csr_write(CSR_HOME, home);
      csr_write(CSR_END, end_key);
      csr_write(CSR_DELETE, del);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [BYTE_W-1:0] opening [$];
      sb = new();
      cycles = 0;
      sent = 0;
      burst_left = 0;
      stall_mode = 0;
      stall_left = 0;
      stall_tick = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_byte_in <= '0;
      rsp_ready <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_BACKSPACE;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain bytes, cursor up, end, delete with two numbers, restart then home,
      // saturated first number ending on a semicolon in the second number
      opening = '{8'h00, 8'hFF, CH_CTRL_C, CH_CR, CH_LF, BACKSPACE_RESET,
                  CH_ESC, CH_UP,
                  CH_ESC, CH_LBRACK, "4", CH_TILDE,
                  CH_ESC, CH_LBRACK, "3", CH_SEMI, "7", CH_TILDE,
                  CH_ESC, CH_LBRACK, CH_ESC, CH_LBRACK, "1", CH_TILDE,
                  CH_ESC, CH_LBRACK, "9", "9", "9", "9", "9", CH_SEMI, CH_SEMI};
      foreach (opening[i]) send_byte(opening[i]);
      run_random(240);

      wait_idle();
      set_regs(8'h00, 16'd0, NUM_MAX, 16'd0);
      run_random(460);

      wait_idle();
      set_regs(CH_CTRL_C, NUM_MAX, NUM_MAX, 16'd2);
      run_random(680);

      wait_idle();
      set_regs(8'hFF, NUM_W'($urandom_range(0, 12)), NUM_W'($urandom_range(0, 12)),
               NUM_W'($urandom_range(0, 12)));
      run_random(900);

      wait_idle();
      set_regs(CH_CR, NUM_W'($urandom_range(0, 65535)), NUM_W'($urandom_range(0, 99)),
               NUM_W'($urandom_range(0, 9)));
      run_random(1100);

      wait_idle();
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### terminal_key_sequence_decoder.f
+incdir+sv
sv/tksd_pkg.sv
sv/tksd_num_accum.sv
sv/tksd_key_decode.sv
sv/terminal_key_sequence_decoder.sv
sv/tksd_checker.sv
tb/sv/tb_terminal_key_sequence_decoder.sv
